### hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, character constants and character-class functions for the
// configuration line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    // character codes
    localparam logic [7:0] CHAR_HASH    = 8'h23;  // '#'
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;  // '"'
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;  // backslash
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // line feed
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;  // '_'
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_COLON   = 8'h3A;  // ':'
    localparam logic [7:0] CHAR_DOT     = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_DASH    = 8'h2D;  // '-'

    // lexer mode, one-hot
    typedef enum logic [4:0] {
        MODE_BLANK   = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_ESCAPED = 5'b01000,
        MODE_COMMENT = 5'b10000
    } t_mode;

    // one result word
    typedef struct packed {
        logic       append_valid;
        logic [7:0] append_char;
        logic       token_done;
        logic       line_done;
        logic       line_ok;
    } t_result;

    // letters, digits and . : = / - _
    function automatic logic is_word_char(input logic [7:0] c);
        logic res;
        res = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                         CHAR_DOT, CHAR_COLON, CHAR_EQUAL, CHAR_SLASH,
                         CHAR_DASH, CHAR_UNDER});
        return res;
    endfunction

    // space, tab, LF, CR
    function automatic logic is_space_char(input logic [7:0] c);
        logic res;
        res = (c inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_CR});
        return res;
    endfunction

endpackage

### hw/rtl/clt_lexer.sv
// ----------------------------------------------------------------------------
// clt_lexer
// Mode and error registers plus the per-byte step logic. Produces the
// result word for the byte being accepted in the same cycle.
// ----------------------------------------------------------------------------
module clt_lexer
    import clt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output t_result    o_result
);

    t_mode      r_mode;
    t_mode      n_mode;
    logic       r_error;
    logic       n_error;
    t_mode      w_mode;
    t_mode      w_step_mode;
    logic       w_step_error;
    logic [7:0] w_char;
    logic       w_word;
    logic       w_space;
    logic       w_app;
    logic       w_done;

    // end of line is lexed as a newline
    assign w_char  = i_line_end ? CHAR_NEWLINE : i_char_code;
    assign w_word  = is_word_char(w_char);
    assign w_space = is_space_char(w_char);

    // codes outside the one-hot set behave as blank
    always_comb begin
        case (r_mode)
            MODE_BLANK, MODE_WORD, MODE_QUOTED, MODE_ESCAPED, MODE_COMMENT: begin
                w_mode = r_mode;
            end
            default: begin
                w_mode = MODE_BLANK;
            end
        endcase
    end

    // one lexer step
    always_comb begin
        w_step_mode  = w_mode;
        w_step_error = r_error;
        w_app        = 1'b0;
        w_done       = 1'b0;
        if (!r_error) begin
            case (w_mode)
                MODE_BLANK: begin
                    if (w_word) begin
                        w_step_mode = MODE_WORD;
                        w_app       = 1'b1;
                    end else if (w_char == CHAR_QUOTE) begin
                        w_step_mode = MODE_QUOTED;
                    end else if (w_space) begin
                        w_step_mode = MODE_BLANK;
                    end else if (w_char == CHAR_HASH) begin
                        w_step_mode = MODE_COMMENT;
                    end else begin
                        w_step_error = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (w_word) begin
                        w_app = 1'b1;
                    end else if (w_space) begin
                        w_done      = 1'b1;
                        w_step_mode = MODE_BLANK;
                    end else if (w_char == CHAR_HASH) begin
                        // partial word dropped, no token end
                        w_step_mode = MODE_COMMENT;
                    end else begin
                        w_step_error = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (w_char == CHAR_QUOTE) begin
                        w_done      = 1'b1;
                        w_step_mode = MODE_BLANK;
                    end else if (w_char == CHAR_BSLASH) begin
                        w_step_mode = MODE_ESCAPED;
                    end else begin
                        w_app = 1'b1;
                    end
                end
                MODE_ESCAPED: begin
                    w_app       = 1'b1;
                    w_step_mode = MODE_QUOTED;
                end
                default: begin
                    // comment: ignore everything
                end
            endcase
        end
    end

    // result word
    always_comb begin
        o_result.append_valid = w_app;
        o_result.append_char  = w_app ? w_char : 8'h00;
        o_result.token_done   = w_done;
        o_result.line_done    = i_line_end;
        o_result.line_ok      = i_line_end && !w_step_error &&
                                (w_step_mode == MODE_BLANK ||
                                 w_step_mode == MODE_COMMENT);
    end

    // next state: end of line returns to reset state
    always_comb begin
        n_mode  = r_mode;
        n_error = r_error;
        if (i_accept) begin
            if (i_line_end) begin
                n_mode  = MODE_BLANK;
                n_error = 1'b0;
            end else begin
                n_mode  = w_step_mode;
                n_error = w_step_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BLANK;
            r_error <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_error <= n_error;
        end
    end

endmodule

### hw/rtl/clt_out_stage.sv
// ----------------------------------------------------------------------------
// clt_out_stage
// Result register with valid/ready handshake. Takes a new word whenever it
// is empty or its word is taken in the same cycle.
// ----------------------------------------------------------------------------
module clt_out_stage
    import clt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // room when empty or draining this cycle
    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/config_line_tokenizer.sv
// ----------------------------------------------------------------------------
// config_line_tokenizer
// Each accepted byte has its result word loaded into the output register.
// Throughput: 1 byte per cycle while the output register has room; mode
// and result registers update together, so a byte can enter each such cycle.
// Reset: synchronous active-low i_rst_n sets blank mode, clears the error
// flag and empties the output register.
// ----------------------------------------------------------------------------
module config_line_tokenizer
    import clt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_append_valid,
    output logic [7:0] o_append_char,
    output logic       o_token_done,
    output logic       o_line_done,
    output logic       o_line_ok
);

    logic    w_accept;
    logic    w_space;
    t_result w_step_result;
    t_result w_out_result;

    // input word taken when the output register has room
    assign o_in_ready = w_space;
    assign w_accept   = i_in_valid && w_space;

    clt_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .o_result    (w_step_result)
    );

    clt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_step_result),
        .o_space  (w_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    assign o_append_valid = w_out_result.append_valid;
    assign o_append_char  = w_out_result.append_char;
    assign o_token_done   = w_out_result.token_done;
    assign o_line_done    = w_out_result.line_done;
    assign o_line_ok      = w_out_result.line_ok;

endmodule

### verif/tb_config_line_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_config_line_tokenizer
// Self-checking bench for the configuration line lexer. Lines of bytes are
// fed through the input channel. An in-bench lexer predicts the result word
// for every accepted byte. Each result word is compared field by field with
// the oldest prediction. Runs a directed line set, then random lines: mostly
// well-formed tokens, plus broken lines and raw noise. Both channel sides
// are throttled in separate phases.
// ----------------------------------------------------------------------------
module tb_config_line_tokenizer
    import clt_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last word

    // one input word for the lexer
    typedef struct {
        logic [7:0] code;
        logic       eol;
    } t_lex_item;

    // DUT ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic       i_line_end  = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_append_valid;
    logic [7:0] o_append_char;
    logic       o_token_done;
    logic       o_line_done;
    logic       o_line_ok;

    // stimulus and scoreboard
    t_lex_item  pending_bytes[$];
    t_result    predicted_words[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         live_items     = 0;
    int         bytes_in       = 0;
    int         words_checked  = 0;
    int         tokens_seen    = 0;
    int         lines_seen     = 0;
    int         good_lines     = 0;
    int         fail_count     = 0;
    int         idle_cycles    = 0;

    // predictor state
    t_mode      lex_mode = MODE_BLANK;
    logic       lex_err  = 1'b0;

    config_line_tokenizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_append_valid (o_append_valid),
        .o_append_char  (o_append_char),
        .o_token_done   (o_token_done),
        .o_line_done    (o_line_done),
        .o_line_ok      (o_line_ok)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic bit is_token_byte(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 1'b1;
        if (c >= "a" && c <= "z") return 1'b1;
        if (c >= "0" && c <= "9") return 1'b1;
        case (c)
            CHAR_DOT, CHAR_COLON, CHAR_EQUAL, CHAR_SLASH, CHAR_DASH, CHAR_UNDER:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic bit is_gap_byte(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_CR;
    endfunction

    // ------------------------------------------------------------------------
    // lexer prediction: one result word per accepted byte
    // ------------------------------------------------------------------------
    function automatic t_result lex_step(input logic [7:0] raw, input logic eol);
        t_result    r;
        logic [7:0] c;
        c = eol ? CHAR_NEWLINE : raw;
        r = '0;
        if (!lex_err) begin
            case (lex_mode)
                MODE_BLANK: begin
                    if (is_token_byte(c)) begin
                        lex_mode = MODE_WORD;
                        r.append_valid = 1'b1;
                    end else if (c == CHAR_QUOTE) begin
                        lex_mode = MODE_QUOTED;
                    end else if (is_gap_byte(c)) begin
                        lex_mode = MODE_BLANK;
                    end else if (c == CHAR_HASH) begin
                        lex_mode = MODE_COMMENT;
                    end else begin
                        lex_err = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_token_byte(c)) begin
                        r.append_valid = 1'b1;
                    end else if (is_gap_byte(c)) begin
                        r.token_done = 1'b1;
                        lex_mode = MODE_BLANK;
                    end else if (c == CHAR_HASH) begin
                        // partial word is dropped, no token end
                        lex_mode = MODE_COMMENT;
                    end else begin
                        lex_err = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (c == CHAR_QUOTE) begin
                        r.token_done = 1'b1;
                        lex_mode = MODE_BLANK;
                    end else if (c == CHAR_BSLASH) begin
                        lex_mode = MODE_ESCAPED;
                    end else begin
                        r.append_valid = 1'b1;
                    end
                end
                MODE_ESCAPED: begin
                    r.append_valid = 1'b1;
                    lex_mode = MODE_QUOTED;
                end
                default: begin
                    // comment: everything ignored
                end
            endcase
        end
        if (r.append_valid) r.append_char = c;
        r.line_done = eol;
        if (eol) begin
            r.line_ok = !lex_err && (lex_mode == MODE_BLANK || lex_mode == MODE_COMMENT);
            lex_mode = MODE_BLANK;
            lex_err  = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    // live = 0 for bytes the lexer just drops (comment body, after an error)
    task automatic add_byte(input logic [7:0] code, input bit live);
        t_lex_item it;
        it.code = code;
        it.eol  = 1'b0;
        pending_bytes = {pending_bytes, it};
        if (live) live_items++;
    endtask

    task automatic add_eol();
        t_lex_item it;
        it.code = 8'($urandom_range(0, 255));
        it.eol  = 1'b1;
        pending_bytes = {pending_bytes, it};
        live_items++;
    endtask

    function automatic logic [7:0] rand_token_byte();
        int pick;
        pick = $urandom_range(0, 67);
        if (pick < 26) return 8'("A" + pick);
        if (pick < 52) return 8'("a" + pick - 26);
        if (pick < 62) return 8'("0" + pick - 52);
        case (pick)
            62:      return CHAR_DOT;
            63:      return CHAR_COLON;
            64:      return CHAR_EQUAL;
            65:      return CHAR_SLASH;
            66:      return CHAR_DASH;
            default: return CHAR_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] rand_gap_byte();
        case ($urandom_range(0, 3))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_CR;
            default: return CHAR_NEWLINE;
        endcase
    endfunction

    // any byte that is neither a token char, a gap, a quote nor a hash
    function automatic logic [7:0] rand_bad_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_token_byte(c) || is_gap_byte(c) || c == CHAR_QUOTE || c == CHAR_HASH);
        return c;
    endfunction

    task automatic add_bare_word();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) add_byte(rand_token_byte(), 1'b1);
    endtask

    // quoted body bytes, escapes included; no closing quote
    task automatic add_quoted_body();
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                add_byte(CHAR_BSLASH, 1'b1);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (c == CHAR_QUOTE || c == CHAR_BSLASH);
                add_byte(c, 1'b1);
            end
        end
    endtask

    task automatic add_comment();
        int n;
        n = $urandom_range(0, 5);
        add_byte(CHAR_HASH, 1'b1);
        repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic add_random_line();
        int kind;
        int ntok;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // well-formed: tokens split by gaps, maybe a trailing comment
            if ($urandom_range(0, 3) == 0) add_byte(rand_gap_byte(), 1'b1);
            ntok = $urandom_range(1, 4);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) begin
                    repeat ($urandom_range(1, 2)) add_byte(rand_gap_byte(), 1'b1);
                end
                if ($urandom_range(0, 2) == 0) begin
                    add_byte(CHAR_QUOTE, 1'b1);
                    add_quoted_body();
                    add_byte(CHAR_QUOTE, 1'b1);
                end else begin
                    add_bare_word();
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0) add_byte(rand_gap_byte(), 1'b1);
                add_comment();
            end
        end else if (kind < 85) begin
            case ($urandom_range(0, 2))
                0: begin
                    // quote left open, sometimes on a pending escape
                    add_byte(CHAR_QUOTE, 1'b1);
                    add_quoted_body();
                    if ($urandom_range(0, 1) == 0) add_byte(CHAR_BSLASH, 1'b1);
                end
                1: begin
                    // word cut short by a comment
                    add_bare_word();
                    add_comment();
                end
                default: begin
                    // illegal byte, rest of line dropped
                    if ($urandom_range(0, 1) == 0) add_bare_word();
                    add_byte(rand_bad_byte(), 1'b1);
                    repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end else begin
            // raw noise
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        add_eol();
    endtask

    task automatic add_random_lines(input int target);
        int start;
        start = live_items;
        while (live_items - start < target) add_random_line();
    endtask

    task automatic add_directed_lines();
        // every mode, both byte extremes, escaped quote, comment line
        add_byte(CHAR_SPACE, 1'b1);
        add_byte("a", 1'b1);
        add_byte("Z", 1'b1);
        add_byte(CHAR_UNDER, 1'b1);
        add_byte(CHAR_TAB, 1'b1);
        add_byte(CHAR_QUOTE, 1'b1);
        add_byte(CHAR_BSLASH, 1'b1);
        add_byte(CHAR_QUOTE, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(CHAR_QUOTE, 1'b1);
        add_byte(CHAR_HASH, 1'b1);
        add_byte("x", 1'b0);
        add_eol();
        // word cut by comment
        add_byte("w", 1'b1);
        add_byte(CHAR_HASH, 1'b1);
        add_eol();
        // open quote: newline gets appended, line bad
        add_byte(CHAR_QUOTE, 1'b1);
        add_byte(8'h00, 1'b1);
        add_eol();
        // illegal byte, then a byte that must be dropped
        add_byte(8'h00, 1'b1);
        add_byte("a", 1'b0);
        add_eol();
        // word closed by the end of line
        add_byte("9", 1'b1);
        add_eol();
    endtask

    // wait until the current phase has fully passed through
    task automatic drain_phase();
        wait (pending_bytes.size() == 0 && !i_in_valid && predicted_words.size() == 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // input driver, prediction at the accepting edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lex_item nxt;
        t_result   pred;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            lex_mode = MODE_BLANK;
            lex_err  = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pred = lex_step(i_char_code, i_line_end);
                predicted_words = {predicted_words, pred};
                bytes_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    i_in_valid  <= 1'b1;
                    i_char_code <= nxt.code;
                    i_line_end  <= nxt.eol;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result word with nothing predicted");
                    fail_count++;
                end else begin
                    want = predicted_words.pop_front();
                    words_checked++;
                    if (o_append_valid !== want.append_valid) begin
                        $error("append_valid: expected %0b, got %0b",
                               want.append_valid, o_append_valid);
                        fail_count++;
                    end
                    if (o_append_char !== want.append_char) begin
                        $error("append_char: expected %02h, got %02h",
                               want.append_char, o_append_char);
                        fail_count++;
                    end
                    if (o_token_done !== want.token_done) begin
                        $error("token_done: expected %0b, got %0b",
                               want.token_done, o_token_done);
                        fail_count++;
                    end
                    if (o_line_done !== want.line_done) begin
                        $error("line_done: expected %0b, got %0b",
                               want.line_done, o_line_done);
                        fail_count++;
                    end
                    if (o_line_ok !== want.line_ok) begin
                        $error("line_ok: expected %0b, got %0b", want.line_ok, o_line_ok);
                        fail_count++;
                    end
                end
                if (o_token_done === 1'b1) tokens_seen++;
                if (o_line_done === 1'b1) lines_seen++;
                if (o_line_done === 1'b1 && o_line_ok === 1'b1) good_lines++;
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no handshake on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // phase sequencing
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (i_rst_n);

        // no throttling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_directed_lines();
        add_random_lines(110);
        drain_phase();

        // sender gaps
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        add_random_lines(140);
        drain_phase();

        // receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        add_random_lines(140);
        drain_phase();

        // light throttling on both sides
        send_idle_pct  = 18;
        recv_stall_pct = 18;
        add_random_lines(140);
        drain_phase();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_words.size() != 0) begin
            $error("%0d predicted words never arrived", predicted_words.size());
            fail_count++;
        end

        $display("Run covered %0d bytes in, %0d result words checked", bytes_in, words_checked);
        $display("  %0d lines (%0d good), %0d tokens closed", lines_seen, good_lines, tokens_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
